// ===== design/sdsh_pkg.sv =====
// Package for the SD card SPI-mode host sequencer.
// Holds phase codes, continuation codes, shared constants and payload types; no dependencies.
package sdsh_pkg;
   localparam int BLOCK_BYTES      = 512;
   localparam int INIT_CLOCK_BYTES = 10;

   localparam logic [1:0] ACT_INIT = 2'd0;
   localparam logic [1:0] ACT_READ = 2'd1;
   localparam logic [1:0] ACT_WRITE = 2'd2;
   localparam logic [1:0] ACT_BYTE = 2'd3;

   localparam logic [1:0] REG_RESP_TRIES = 2'd0;
   localparam logic [1:0] REG_TOKEN_WAIT = 2'd1;
   localparam logic [1:0] REG_SD2_RETRY  = 2'd2;
   localparam logic [1:0] REG_V1_RETRY   = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_IDLE = 2'd1;
   localparam logic [1:0] ST_RD_FAIL = 2'd2;
   localparam logic [1:0] ST_WR_FAIL = 2'd3;

   localparam logic [2:0] TYPE_UNKNOWN = 3'd0;
   localparam logic [2:0] TYPE_MMC3    = 3'd1;
   localparam logic [2:0] TYPE_SD1     = 3'd2;
   localparam logic [2:0] TYPE_SD2_BYTE  = 3'd3;
   localparam logic [2:0] TYPE_SD2_BLOCK = 3'd4;

   localparam logic [5:0] P_IDLE = 6'd0;
   localparam logic [5:0] P_CLOCKS = 6'd1;
   localparam logic [5:0] P_DESEL = 6'd2;
   localparam logic [5:0] P_SEL = 6'd3;
   localparam logic [5:0] P_FRAME = 6'd4;
   localparam logic [5:0] P_POLL = 6'd5;
   localparam logic [5:0] P_REL0 = 6'd6;
   localparam logic [5:0] P_R7 = 6'd7;
   localparam logic [5:0] P_OCR = 6'd8;
   localparam logic [5:0] P_RD_REL = 6'd9;
   localparam logic [5:0] P_RD_TOKEN = 6'd10;
   localparam logic [5:0] P_RD_DATA = 6'd11;
   localparam logic [5:0] P_RD_CRC = 6'd12;
   localparam logic [5:0] P_WR_REL = 6'd13;
   localparam logic [5:0] P_WR_TOKEN = 6'd14;
   localparam logic [5:0] P_WR_DATA = 6'd15;
   localparam logic [5:0] P_WR_TAIL = 6'd16;
   localparam logic [5:0] P_WR_RESP = 6'd17;
   localparam logic [5:0] P_WR_BUSY = 6'd18;

   localparam logic [3:0] K_CMD0 = 4'd0;
   localparam logic [3:0] K_CMD8 = 4'd1;
   localparam logic [3:0] K_A41V2 = 4'd2;
   localparam logic [3:0] K_CMD58 = 4'd3;
   localparam logic [3:0] K_PROBE = 4'd4;
   localparam logic [3:0] K_V1LOOP = 4'd5;
   localparam logic [3:0] K_CMD16 = 4'd6;
   localparam logic [3:0] K_CMD17 = 4'd7;
   localparam logic [3:0] K_CMD24 = 4'd8;

   localparam logic [7:0] BYTE_IDLE  = 8'hFF;
   localparam logic [7:0] DATA_TOKEN = 8'hFE;
   localparam logic [7:0] CRC_CMD0   = 8'h95;
   localparam logic [7:0] CRC_CMD8   = 8'h87;
   localparam logic [7:0] CRC_DUMMY  = 8'h01;
   localparam logic [4:0] DRESP_OK   = 5'h05;

   localparam logic [5:0] CMD_GO_IDLE = 6'd0;
   localparam logic [5:0] CMD_SEND_OP_MMC = 6'd1;
   localparam logic [5:0] CMD_IF_COND = 6'd8;
   localparam logic [5:0] CMD_BLOCKLEN = 6'd16;
   localparam logic [5:0] CMD_READ = 6'd17;
   localparam logic [5:0] CMD_WRITE = 6'd24;
   localparam logic [5:0] CMD_SD_OP = 6'd41;
   localparam logic [5:0] CMD_APP = 6'd55;
   localparam logic [5:0] CMD_READ_OCR = 6'd58;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] block_address;
      logic [7:0]  card_byte;
      logic [7:0]  write_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] send_byte;
      logic       send_valid;
      logic       chip_select;
      logic [7:0] read_byte;
      logic       read_valid;
      logic       write_byte_taken;
      logic       done_res;
      logic [1:0] status;
      logic [2:0] card_type;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  index;
      logic [15:0] data;
   } csr_type;
endpackage

// ===== design/sdsh_if.sv =====
// Valid/ready channel interfaces for the SD card SPI host sequencer.
// Depends on sdsh_pkg for the payload types.
interface sdsh_req_if import sdsh_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface sdsh_rsp_if import sdsh_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface sdsh_csr_if import sdsh_pkg::*; ();
   logic    valid;
   logic    ready;
   csr_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== design/sd_card_spi_host_engine_unit.sv =====
// Top level of the SD card SPI-mode host sequencer.
// Depends on sdsh_pkg and the channel interfaces in sdsh_if.sv.
//
//  channel   direction  payload                                   accepted when
//  req_      in         action, block_address, card_byte, write_byte  valid & ready
//  rsp_      out        send_byte ... card_type (one per request item) valid & ready
//  csr_      in         index, data (register write)               valid & ready
//
// The sequencer state and the result register are updated at the edge that
// accepts an item, so an item can be accepted every cycle unless the result
// is stalled; the single result register sets this rate. req_ready is high
// whenever that register is empty or is being drained in the same cycle.
// Reset (synchronous, active high) returns to idle, deselects the card and
// loads the register defaults. A stalled result holds the input side.
module sd_card_spi_host_engine_unit
   import sdsh_pkg::*;
(
   input logic        clock,
   input logic        reset,
   sdsh_req_if.sink   req,
   sdsh_rsp_if.source rsp,
   sdsh_csr_if.sink   csr
);
   // Configuration registers.
   logic [7:0]  resp_tries_ff;
   logic [15:0] token_wait_ff, sd2_retry_ff, v1_retry_ff;

   // Sequencer state.
   logic [5:0]  phase_ff, phase_in;
   logic [1:0]  operation_ff, operation_in;
   logic [15:0] byte_count_ff, byte_count_in;
   logic [15:0] retry_count_ff, retry_count_in;
   logic [7:0]  poll_count_ff, poll_count_in;
   logic [5:0]  cmd_index_ff, cmd_index_in;
   logic [31:0] cmd_arg_ff, cmd_arg_in;
   logic        app_pend_ff, app_pend_in;
   logic [31:0] ocr_ff, ocr_in;
   logic [2:0]  det_type_ff, det_type_in;
   logic [3:0]  cont_ff, cont_in;
   logic        cs_ff, cs_in;

   // Result register.
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   logic accept;
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         resp_tries_ff <= 8'd10;
         token_wait_ff <= 16'hFFFF;
         sd2_retry_ff  <= 16'd12000;
         v1_retry_ff   <= 16'd25000;
      end else if (csr.valid) begin
         case (csr.payload.index)
            REG_RESP_TRIES: resp_tries_ff <= csr.payload.data[7:0];
            REG_TOKEN_WAIT: token_wait_ff <= csr.payload.data;
            REG_SD2_RETRY:  sd2_retry_ff  <= csr.payload.data;
            REG_V1_RETRY:   v1_retry_ff   <= csr.payload.data;
            default: ;
         endcase
      end
   end

   // Next-state logic; one pass per accepted item.
   always_comb begin
      logic [16:0] n;
      logic [7:0]  b, pc, fb;
      logic [5:0]  fidx;
      logic [31:0] farg;
      logic [15:0] rc;
      logic        cmd_start, frame_start, fin, go_v2, go_v1;
      logic [5:0]  s_idx;
      logic [31:0] s_arg;
      logic        s_app;
      logic [3:0]  s_cont;
      logic [1:0]  fin_st;
      logic [31:0] ocr_sh;

      phase_in = phase_ff; operation_in = operation_ff;
      byte_count_in = byte_count_ff; retry_count_in = retry_count_ff;
      poll_count_in = poll_count_ff; cmd_index_in = cmd_index_ff;
      cmd_arg_in = cmd_arg_ff; app_pend_in = app_pend_ff; ocr_in = ocr_ff;
      det_type_in = det_type_ff; cont_in = cont_ff; cs_in = cs_ff;
      rsp_data_in = '0;

      n = {1'b0, byte_count_ff} + 17'd1;
      b = req.payload.card_byte;
      pc = poll_count_ff + 8'd1;
      rc = retry_count_ff;
      cmd_start = 1'b0; frame_start = 1'b0; fin = 1'b0; fin_st = ST_OK;
      go_v2 = 1'b0; go_v1 = 1'b0;
      s_idx = '0; s_arg = '0; s_app = 1'b0; s_cont = K_CMD0;
      ocr_sh = {ocr_ff[23:0], b};

      // Frame byte for the command currently held.
      fidx = app_pend_ff ? CMD_APP : cmd_index_ff;
      farg = app_pend_ff ? 32'd0 : cmd_arg_ff;
      case (n[2:0])
         3'd1: fb = farg[31:24];
         3'd2: fb = farg[23:16];
         3'd3: fb = farg[15:8];
         3'd4: fb = farg[7:0];
         default: fb = (fidx == CMD_GO_IDLE) ? CRC_CMD0 :
                       (fidx == CMD_IF_COND) ? CRC_CMD8 : CRC_DUMMY;
      endcase

      case (req.payload.action)
         ACT_INIT: begin
            operation_in = 2'd0; det_type_in = TYPE_UNKNOWN; app_pend_in = 1'b0;
            cs_in = 1'b0; byte_count_in = '0; phase_in = P_CLOCKS;
            rsp_data_in.send_byte = BYTE_IDLE; rsp_data_in.send_valid = 1'b1;
         end
         ACT_READ: begin
            operation_in = 2'd1; cmd_start = 1'b1;
            s_idx = CMD_READ; s_arg = req.payload.block_address; s_cont = K_CMD17;
         end
         ACT_WRITE: begin
            operation_in = 2'd2; cmd_start = 1'b1;
            s_idx = CMD_WRITE; s_arg = req.payload.block_address; s_cont = K_CMD24;
         end
         default: begin
            case (phase_ff)
               P_CLOCKS: begin
                  byte_count_in = n[15:0];
                  if (n < 17'(INIT_CLOCK_BYTES)) begin
                     rsp_data_in.send_byte = BYTE_IDLE; rsp_data_in.send_valid = 1'b1;
                  end else begin
                     cmd_start = 1'b1; s_idx = CMD_GO_IDLE; s_cont = K_CMD0;
                  end
               end
               P_DESEL: begin
                  cs_in = 1'b1; phase_in = P_SEL;
                  rsp_data_in.send_byte = BYTE_IDLE; rsp_data_in.send_valid = 1'b1;
               end
               P_SEL: begin
                  phase_in = P_FRAME; byte_count_in = '0;
                  rsp_data_in.send_byte = 8'h40 | {2'b00, fidx};
                  rsp_data_in.send_valid = 1'b1;
               end
               P_FRAME: begin
                  byte_count_in = n[15:0];
                  rsp_data_in.send_valid = 1'b1;
                  if (n < 17'd6) rsp_data_in.send_byte = fb;
                  else begin
                     phase_in = P_POLL; poll_count_in = '0;
                     rsp_data_in.send_byte = BYTE_IDLE;
                  end
               end
               P_POLL: begin
                  poll_count_in = pc;
                  if (b[7] && pc != resp_tries_ff) begin
                     rsp_data_in.send_byte = BYTE_IDLE; rsp_data_in.send_valid = 1'b1;
                  end else if (app_pend_ff && b <= 8'd1) begin
                     app_pend_in = 1'b0; frame_start = 1'b1;
                  end else begin
                     app_pend_in = 1'b0;
                     case (cont_ff)
                        K_CMD0: begin
                           if (b == 8'd1) begin
                              phase_in = P_REL0;
                              rsp_data_in.send_byte = BYTE_IDLE;
                              rsp_data_in.send_valid = 1'b1;
                           end else begin
                              fin = 1'b1; fin_st = ST_NO_IDLE;
                           end
                        end
                        K_CMD8: begin
                           if (b == 8'd1) begin
                              phase_in = P_R7; byte_count_in = '0; ocr_in = '0;
                              rsp_data_in.send_byte = BYTE_IDLE;
                              rsp_data_in.send_valid = 1'b1;
                           end else begin
                              cmd_start = 1'b1; s_idx = CMD_SD_OP; s_app = 1'b1;
                              s_cont = K_PROBE;
                           end
                        end
                        K_A41V2: begin
                           if (b != 8'd0) begin
                              rc = retry_count_ff - 16'd1; go_v2 = 1'b1;
                           end else begin
                              cmd_start = 1'b1; s_idx = CMD_READ_OCR; s_cont = K_CMD58;
                           end
                        end
                        K_CMD58: begin
                           if (b == 8'd0) begin
                              phase_in = P_OCR; byte_count_in = '0; ocr_in = '0;
                              rsp_data_in.send_byte = BYTE_IDLE;
                              rsp_data_in.send_valid = 1'b1;
                           end else fin = 1'b1;
                        end
                        K_PROBE: begin
                           det_type_in = (b <= 8'd1) ? TYPE_SD1 : TYPE_MMC3;
                           rc = v1_retry_ff; go_v1 = 1'b1;
                        end
                        K_V1LOOP: begin
                           if (b != 8'd0) begin
                              rc = retry_count_ff - 16'd1; go_v1 = 1'b1;
                           end else begin
                              cmd_start = 1'b1; s_idx = CMD_BLOCKLEN;
                              s_arg = 32'(BLOCK_BYTES); s_cont = K_CMD16;
                           end
                        end
                        K_CMD16: begin
                           if (b != 8'd0) det_type_in = TYPE_UNKNOWN;
                           fin = 1'b1;
                        end
                        K_CMD17: begin
                           if (b != 8'd0) begin
                              fin = 1'b1; fin_st = ST_RD_FAIL;
                           end else begin
                              phase_in = P_RD_REL;
                              rsp_data_in.send_byte = BYTE_IDLE;
                              rsp_data_in.send_valid = 1'b1;
                           end
                        end
                        default: begin
                           if (b != 8'd0) begin
                              fin = 1'b1; fin_st = ST_WR_FAIL;
                           end else begin
                              phase_in = P_WR_REL;
                              rsp_data_in.send_byte = BYTE_IDLE;
                              rsp_data_in.send_valid = 1'b1;
                           end
                        end
                     endcase
                  end
               end
               P_REL0: begin
                  cmd_start = 1'b1; s_idx = CMD_IF_COND; s_arg = 32'h1AA;
                  s_cont = K_CMD8;
               end
               P_R7, P_OCR: begin
                  ocr_in = ocr_sh; byte_count_in = n[15:0];
                  if (n < 17'd4) begin
                     rsp_data_in.send_byte = BYTE_IDLE; rsp_data_in.send_valid = 1'b1;
                  end else if (phase_ff == P_OCR) begin
                     det_type_in = ocr_sh[30] ? TYPE_SD2_BLOCK : TYPE_SD2_BYTE;
                     fin = 1'b1;
                  end else if (ocr_sh[15:0] == 16'h01AA) begin
                     rc = sd2_retry_ff; go_v2 = 1'b1;
                  end else fin = 1'b1;
               end
               P_RD_REL: begin
                  phase_in = P_RD_TOKEN; byte_count_in = '0;
                  rsp_data_in.send_byte = BYTE_IDLE; rsp_data_in.send_valid = 1'b1;
               end
               P_RD_TOKEN, P_WR_BUSY: begin
                  byte_count_in = n[15:0];
                  if (n >= {1'b0, token_wait_ff}) begin
                     fin = 1'b1;
                     fin_st = (phase_ff == P_RD_TOKEN) ? ST_RD_FAIL : ST_WR_FAIL;
                  end else if (b != ((phase_ff == P_RD_TOKEN) ? DATA_TOKEN : BYTE_IDLE))
                  begin
                     rsp_data_in.send_byte = BYTE_IDLE; rsp_data_in.send_valid = 1'b1;
                  end else if (phase_ff == P_WR_BUSY) fin = 1'b1;
                  else begin
                     phase_in = P_RD_DATA; byte_count_in = '0;
                     rsp_data_in.send_byte = BYTE_IDLE; rsp_data_in.send_valid = 1'b1;
                  end
               end
               P_RD_DATA: begin
                  rsp_data_in.read_byte = b; rsp_data_in.read_valid = 1'b1;
                  byte_count_in = n[15:0];
                  rsp_data_in.send_byte = BYTE_IDLE; rsp_data_in.send_valid = 1'b1;
                  if (n >= 17'(BLOCK_BYTES)) begin
                     phase_in = P_RD_CRC; byte_count_in = '0;
                  end
               end
               P_RD_CRC: begin
                  byte_count_in = n[15:0];
                  if (n < 17'd2) begin
                     rsp_data_in.send_byte = BYTE_IDLE; rsp_data_in.send_valid = 1'b1;
                  end else fin = 1'b1;
               end
               P_WR_REL: begin
                  phase_in = P_WR_TOKEN;
                  rsp_data_in.send_byte = DATA_TOKEN; rsp_data_in.send_valid = 1'b1;
               end
               P_WR_TOKEN: begin
                  phase_in = P_WR_DATA; byte_count_in = '0;
                  rsp_data_in.send_byte = req.payload.write_byte;
                  rsp_data_in.send_valid = 1'b1; rsp_data_in.write_byte_taken = 1'b1;
               end
               P_WR_DATA: begin
                  byte_count_in = n[15:0]; rsp_data_in.send_valid = 1'b1;
                  if (n < 17'(BLOCK_BYTES)) begin
                     rsp_data_in.send_byte = req.payload.write_byte;
                     rsp_data_in.write_byte_taken = 1'b1;
                  end else begin
                     phase_in = P_WR_TAIL; byte_count_in = '0;
                     rsp_data_in.send_byte = BYTE_IDLE;
                  end
               end
               P_WR_TAIL: begin
                  byte_count_in = n[15:0];
                  if (n >= 17'd2) phase_in = P_WR_RESP;
                  rsp_data_in.send_byte = BYTE_IDLE; rsp_data_in.send_valid = 1'b1;
               end
               P_WR_RESP: begin
                  if (b[4:0] != DRESP_OK) begin
                     fin = 1'b1; fin_st = ST_WR_FAIL;
                  end else begin
                     phase_in = P_WR_BUSY; byte_count_in = '0;
                     rsp_data_in.send_byte = BYTE_IDLE; rsp_data_in.send_valid = 1'b1;
                  end
               end
               default: ;
            endcase
         end
      endcase

      // Retry loops: give up when the count is exhausted.
      if (go_v2) begin
         retry_count_in = rc;
         if (rc == 16'd0) fin = 1'b1;
         else begin
            cmd_start = 1'b1; s_idx = CMD_SD_OP; s_arg = 32'h4000_0000;
            s_app = 1'b1; s_cont = K_A41V2;
         end
      end
      if (go_v1) begin
         retry_count_in = rc;
         if (rc == 16'd0) begin
            det_type_in = TYPE_UNKNOWN; fin = 1'b1;
         end else if (det_type_in == TYPE_SD1) begin
            cmd_start = 1'b1; s_idx = CMD_SD_OP; s_app = 1'b1; s_cont = K_V1LOOP;
         end else begin
            cmd_start = 1'b1; s_idx = CMD_SEND_OP_MMC; s_cont = K_V1LOOP;
         end
      end
      if (cmd_start) begin
         cmd_index_in = s_idx; cmd_arg_in = s_arg; app_pend_in = s_app;
         cont_in = s_cont; frame_start = 1'b1;
      end
      if (frame_start) begin
         phase_in = P_DESEL; cs_in = 1'b0;
         rsp_data_in.send_byte = BYTE_IDLE; rsp_data_in.send_valid = 1'b1;
      end
      if (fin) begin
         phase_in = P_IDLE; rsp_data_in.done_res = 1'b1; rsp_data_in.status = fin_st;
      end
      rsp_data_in.chip_select = cs_in;
      rsp_data_in.card_type = det_type_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE; operation_ff <= '0; byte_count_ff <= '0;
         retry_count_ff <= '0; poll_count_ff <= '0; cmd_index_ff <= '0;
         cmd_arg_ff <= '0; app_pend_ff <= 1'b0; ocr_ff <= '0;
         det_type_ff <= TYPE_UNKNOWN; cont_ff <= K_CMD0; cs_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in; operation_ff <= operation_in;
            byte_count_ff <= byte_count_in; retry_count_ff <= retry_count_in;
            poll_count_ff <= poll_count_in; cmd_index_ff <= cmd_index_in;
            cmd_arg_ff <= cmd_arg_in; app_pend_ff <= app_pend_in; ocr_ff <= ocr_in;
            det_type_ff <= det_type_in; cont_ff <= cont_in; cs_ff <= cs_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   // An idle sequencer answers a card byte with no exchange.
   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == P_IDLE && req.payload.action == ACT_BYTE
      |=> !rsp_data_ff.send_valid && !rsp_data_ff.done_res)
      else $error("idle sequencer produced output");
   // Finishing a request always returns the phase to idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      accept && rsp_data_in.done_res |=> phase_ff == P_IDLE)
      else $error("done without idle phase");
   // Read data and write data are never reported together.
   a_rd_wr_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.read_valid && rsp_data_ff.write_byte_taken))
      else $error("read and write data in one item");
   // A held result does not change while stalled.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> $stable(rsp_data_ff))
      else $error("stalled result changed");
`endif
endmodule
